FILE: rtl/core/ocsp_message_classifier_core_macros.svh
// Assertion macros shared by the OCSP message classifier RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef OCSP_MESSAGE_CLASSIFIER_CORE_MACROS_SVH
`define OCSP_MESSAGE_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OCSPMC_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("ocspmc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OCSPMC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("ocspmc assertion failed");

`endif

FILE: rtl/core/ocspmc_pkg.sv
// Types and constants of the OCSP message classifier.
// Used by ocspmc_parser and ocsp_message_classifier_core; depends on nothing.
package ocspmc_pkg;

	// DER tags and certStatus pattern bytes.
	localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
	localparam logic [7:0] TAG_ENUMERATED = 8'h0A;
	localparam logic [7:0] LEN_LONG       = 8'h80;
	localparam logic [6:0] LEN_MASK       = 7'h7F;
	localparam logic [7:0] CS_GOOD_TAG    = 8'h80;
	localparam logic [7:0] CS_REVOKED_TAG = 8'hA1;
	localparam logic [7:0] CS_UNKNOWN_TAG = 8'h82;
	localparam logic [7:0] CS_PAD         = 8'h00;

	// Header length of a short-form element and the longest exact long form.
	localparam logic [7:0] HDR_LEN_SHORT  = 8'd2;
	localparam int         MAX_LEN_BYTES  = 4;

	typedef enum logic [1:0] {
		PARSE_OK        = 2'd0,
		PARSE_TRUNCATED = 2'd1,
		PARSE_BAD_TAG   = 2'd2
	} parse_status_t;

	typedef enum logic [1:0] {
		CERT_GOOD    = 2'd0,
		CERT_REVOKED = 2'd1,
		CERT_UNKNOWN = 2'd2
	} cert_status_t;

	// One byte leaving the input register into the parser.
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       last_byte;
	} step_t;

	// Result of one message.
	typedef struct packed {
		parse_status_t parse_status;
		logic          is_request;
		logic [7:0]    response_status;
		logic          cert_found;
		cert_status_t  cert_status;
		logic [31:0]   consumed_length;
	} result_t;

endpackage

FILE: rtl/core/ocspmc_parser.sv
// Per-byte DER header decoder, message classifier and certStatus scanner.
// Holds the message state; depends on ocspmc_pkg.
module ocspmc_parser #(
	parameter int COUNT_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ocspmc_pkg::step_t    step,
	output ocspmc_pkg::result_t  result
);
	import ocspmc_pkg::*;

	// Compare width holds the byte count plus one and header plus content length.
	localparam int CMP_W = (COUNT_BITS > 33) ? COUNT_BITS + 1 : 34;

	logic [COUNT_BITS-1:0] pos_q, pos_d;
	logic [7:0]            hl_q, hl_d;
	logic [31:0]           cl_q, cl_d;
	logic                  sat_q, sat_d;
	logic                  tag_bad_q, tag_bad_d;
	logic                  resp_q, resp_d;
	logic                  inner_q, inner_d;
	logic [7:0]            prev_q, prev_d;
	logic [7:0]            status_q, status_d;
	logic                  hit_q, hit_d;
	cert_status_t          code_q, code_d;

	logic [7:0]      b;
	logic [CMP_W-1:0] p_w, hl_w, span_w, n_w, total_w, cons_w;

	// Next state for the byte in flight.
	always_comb begin
		b        = step.data_byte;
		p_w      = CMP_W'(pos_q);
		hl_w     = CMP_W'(hl_q);
		span_w   = CMP_W'(hl_q) + CMP_W'(cl_q);
		pos_d    = pos_q;
		hl_d     = hl_q;
		cl_d     = cl_q;
		sat_d    = sat_q;
		tag_bad_d = tag_bad_q;
		resp_d   = resp_q;
		inner_d  = inner_q;
		status_d = status_q;
		hit_d    = hit_q;
		code_d   = code_q;
		if (pos_q == '0) begin
			tag_bad_d = (b != TAG_SEQUENCE);
		end else if (pos_q == COUNT_BITS'(1)) begin
			if (b < LEN_LONG) begin
				cl_d = 32'(b);
				hl_d = HDR_LEN_SHORT;
			end else begin
				cl_d = '0;
				hl_d = HDR_LEN_SHORT + 8'(b[6:0] & LEN_MASK);
			end
		end else if (p_w < hl_w) begin
			// Long-form length bytes; beyond four the length saturates.
			if (p_w >= CMP_W'(2 + MAX_LEN_BYTES)) begin
				sat_d = 1'b1;
				cl_d  = '1;
			end else if (!sat_q) begin
				cl_d = {cl_q[23:0], b};
			end
		end else begin
			// Content: kind, responseStatus and the certStatus scan.
			if (p_w == hl_w) begin
				inner_d = 1'b1;
				resp_d  = (b == TAG_ENUMERATED);
			end
			if (p_w == hl_w + CMP_W'(2))
				status_d = b;
			if (resp_q && !hit_q && p_w >= hl_w + CMP_W'(1) && p_w < span_w) begin
				if (prev_q == CS_GOOD_TAG && b == CS_PAD) begin
					hit_d  = 1'b1;
					code_d = CERT_GOOD;
				end else if (prev_q == CS_REVOKED_TAG) begin
					hit_d  = 1'b1;
					code_d = CERT_REVOKED;
				end else if (prev_q == CS_UNKNOWN_TAG && b == CS_PAD) begin
					hit_d  = 1'b1;
					code_d = CERT_UNKNOWN;
				end
			end
		end
		prev_d = b;
		if (pos_q != '1)
			pos_d = pos_q + COUNT_BITS'(1);
	end

	// Result as seen after the last byte has been taken into the state.
	always_comb begin
		if (COUNT_BITS >= 64 && pos_q == '1)
			n_w = p_w;
		else
			n_w = p_w + CMP_W'(1);
		total_w = CMP_W'(hl_d) + CMP_W'(cl_d);
		cons_w  = (total_w < n_w) ? total_w : n_w;
		result  = '0;
		if (n_w < CMP_W'(3)) begin
			result.parse_status = PARSE_TRUNCATED;
		end else if (tag_bad_d) begin
			result.parse_status = PARSE_BAD_TAG;
		end else if (n_w < CMP_W'(hl_d)) begin
			result.parse_status = PARSE_TRUNCATED;
		end else begin
			result.parse_status = PARSE_OK;
			result.is_request   = inner_d && !resp_d;
			if (resp_d) begin
				if (CMP_W'(hl_d) + CMP_W'(2) < n_w)
					result.response_status = status_d;
				result.cert_found  = hit_d;
				result.cert_status = hit_d ? code_d : CERT_GOOD;
			end
			if (cons_w > CMP_W'(32'hFFFF_FFFF))
				result.consumed_length = '1;
			else
				result.consumed_length = cons_w[31:0];
		end
	end

	// Message state; a last byte puts it back to the start of a message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			hl_q      <= HDR_LEN_SHORT;
			cl_q      <= '0;
			sat_q     <= 1'b0;
			tag_bad_q <= 1'b0;
			resp_q    <= 1'b0;
			inner_q   <= 1'b0;
			prev_q    <= '0;
			status_q  <= '0;
			hit_q     <= 1'b0;
			code_q    <= CERT_GOOD;
		end else if (step.valid) begin
			if (step.last_byte) begin
				pos_q     <= '0;
				hl_q      <= HDR_LEN_SHORT;
				cl_q      <= '0;
				sat_q     <= 1'b0;
				tag_bad_q <= 1'b0;
				resp_q    <= 1'b0;
				inner_q   <= 1'b0;
				prev_q    <= '0;
				status_q  <= '0;
				hit_q     <= 1'b0;
				code_q    <= CERT_GOOD;
			end else begin
				pos_q     <= pos_d;
				hl_q      <= hl_d;
				cl_q      <= cl_d;
				sat_q     <= sat_d;
				tag_bad_q <= tag_bad_d;
				resp_q    <= resp_d;
				inner_q   <= inner_d;
				prev_q    <= prev_d;
				status_q  <= status_d;
				hit_q     <= hit_d;
				code_q    <= code_d;
			end
		end
	end

endmodule

FILE: rtl/core/ocsp_message_classifier_core.sv
// OCSP message classifier: takes one byte per cycle unless stalled, one result per
// message on its last byte. An input register feeds the parser, whose result is
// held in an output register. The block accepts one word each cycle that ready
// is high; a word waits in the input register before the parser, and the result of a
// message is offered on the cycle after its last byte leaves the input
// register. Input ready drops only while a last byte waits in the input
// register for the output register, which frees when the downstream side takes
// the previous result. Depends on ocspmc_pkg, ocspmc_parser and the macro header.
`include "ocsp_message_classifier_core_macros.svh"

module ocsp_message_classifier_core #(
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata    // [1:0] parse_status, [2] is_request,
	                                    // [10:3] response_status, [11] cert_found,
	                                    // [13:12] cert_status, [45:14] consumed_length,
	                                    // [47:46] zero
);
	import ocspmc_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       out_valid_q;
	result_t    result_q;
	result_t    result;
	step_t      step;
	logic       out_free;
	logic       s1_adv;

	// A word leaves the input register unless it is a last byte and the
	// output register is still occupied.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_adv        = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || s1_adv;

	assign step.valid     = s1_adv;
	assign step.data_byte = data_s1;
	assign step.last_byte = last_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	ocspmc_parser #(
		.COUNT_BITS(COUNT_BITS)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.result(result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1)
			result_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, result_q.consumed_length, result_q.cert_status,
		result_q.cert_found, result_q.response_status, result_q.is_request,
		result_q.parse_status};

	// A last byte blocked by a full output register stays in place.
	`OCSPMC_ASSERT_NEXT(a_last_held, clk, arst_n, valid_s1 && last_s1 && out_valid_q && !m_axis_tready, valid_s1 && last_s1 && $stable(data_s1))
	// An empty input register always takes a word.
	`OCSPMC_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !valid_s1, s_axis_tready)
	// A last byte leaving the input register makes the output register valid.
	`OCSPMC_ASSERT_NEXT(a_load_shows, clk, arst_n, s1_adv && last_s1, out_valid_q)
	// An error result carries nothing but its status.
	`OCSPMC_ASSERT_NOW(a_error_clean, clk, arst_n, out_valid_q && m_axis_tdata[1:0] != 2'd0, m_axis_tdata[45:2] == 44'd0)

endmodule
